>>> rtl/core/bmp_header_validator_top_macros.svh
// ----------------------------------------------------------------------------
// BMP header validator assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef BMP_HEADER_VALIDATOR_TOP_MACROS_SVH
`define BMP_HEADER_VALIDATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// check under reset gating
`define BHV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds while reset is asserted
`define BHV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BHV_ASSERT(lbl, prop, msg)
`define BHV_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/core/bhv_pkg.sv
// ----------------------------------------------------------------------------
// bhv_pkg
// Types, codes and lookup functions of the BMP header validator.
// ----------------------------------------------------------------------------
package bhv_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_AVAIL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXDIM = 1'b1;

  localparam logic [1:0] ST_VALID  = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_SHORT  = 2'd2;

  localparam logic [31:0] DIB_CORE   = 32'd12;
  localparam logic [31:0] COMP_JPEG  = 32'd4;
  localparam logic [31:0] COMP_PNG   = 32'd5;
  localparam logic [24:0] MAXDIM_RST = 25'd16777216;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHK,
    S_MUL1,
    S_MUL2
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_flag;
    logic       last_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] total_size;
    logic [31:0] pixel_offset;
    logic [6:0]  dib_size;
    logic [24:0] image_width;
    logic [24:0] image_height;
    logic        rows_top_down;
    logic [6:0]  depth_bits;
    logic [2:0]  compression_kind;
    logic [31:0] stated_image_size;
    logic [31:0] palette_count;
    logic [31:0] overlay_size;
  } out_item_t;

  function automatic logic [31:0] put_lane(logic [31:0] r, logic [1:0] ln, logic [7:0] b);
    return r | ({24'd0, b} << {ln, 3'b000});
  endfunction

  function automatic logic dib_known(logic [31:0] s);
    return (s == 32'd12) || (s == 32'd40) || (s == 32'd108) || (s == 32'd124);
  endfunction

  function automatic logic depth_ok(logic [31:0] dib, logic [15:0] bpp, logic [31:0] comp);
    logic r;
    r = 1'b0;
    if (dib == DIB_CORE) begin
      r = (comp == 32'd0) && ((bpp == 16'd1) || (bpp == 16'd4) || (bpp == 16'd8) ||
                              (bpp == 16'd24));
    end else begin
      case (comp)
        32'd0: r = bpp inside {16'd1, 16'd2, 16'd4, 16'd8, 16'd16, 16'd24, 16'd32, 16'd64};
        32'd1: r = (bpp == 16'd8);
        32'd2: r = (bpp == 16'd4);
        32'd3: r = bpp inside {16'd16, 16'd24, 16'd32};
        32'd6: r = bpp inside {16'd16, 16'd32};
        32'd4, 32'd5: r = bpp inside {16'd0, 16'd1, 16'd2, 16'd4, 16'd8, 16'd16, 16'd24,
                                      16'd32};
        default: r = 1'b0;
      endcase
    end
    return r;
  endfunction

  // expected stream signature byte; png selects the 8-byte form
  function automatic logic [7:0] sig_byte(logic png, logic [3:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (!png) begin
      case (idx)
        4'd0: r = 8'hFF;
        4'd1: r = 8'hD8;
        4'd2: r = 8'hFF;
        default: r = 8'h00;
      endcase
    end else begin
      case (idx)
        4'd0: r = 8'h89;
        4'd1: r = 8'h50;
        4'd2: r = 8'h4E;
        4'd3: r = 8'h47;
        4'd4: r = 8'h0D;
        4'd5: r = 8'h0A;
        4'd6: r = 8'h1A;
        4'd7: r = 8'h0A;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

>>> rtl/core/bmp_header_validator_top.sv
// ----------------------------------------------------------------------------
// bmp_header_validator_top
// Parses and checks the header of a candidate bitmap file, one verdict each.
// ----------------------------------------------------------------------------
// Usage: bytes of a candidate enter on the in_ channel (valid/stall); a byte
// with first_flag restarts the parse, last_flag marks the final byte. Each
// candidate yields one out_ transaction: valid, rejected, or input ended.
// Bytes after a verdict without first_flag are taken and dropped.
// Set available_bytes and max_dimension on the cfg_ port while idle.
// Throughput: one byte per cycle through the header while in_stall is low. At
// the last header byte the sequencer runs the field checks and, for
// uncompressed and bitfield images, two passes through the shared multiplier
// (row bytes, then pixel bytes), during which in_stall is high. A verdict is
// registered in the cycle after the deciding byte, or when the sequencer
// finishes after the last header byte.
// The result sits in an output register; while out_stall is high a new byte
// is taken only when the output register is empty.
// Reset (synchronous, rst_n low) returns to idle, awaiting a first_flag byte.
// ----------------------------------------------------------------------------
`include "bmp_header_validator_top_macros.svh"

module bmp_header_validator_top #(
  parameter int SIZE_BITS = bhv_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bhv_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bhv_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [bhv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import bhv_pkg::*;

  localparam int CW = (SIZE_BITS > 32) ? SIZE_BITS : 32;

  state_t                 state_r, state_nxt;
  logic                   verdict_r, verdict_nxt;
  logic                   last_r, last_nxt;
  logic [SIZE_BITS-1:0]   pos_r, pos_nxt;
  logic [31:0]            fsz_r, fsz_nxt, off_r, off_nxt, dib_r, dib_nxt;
  logic [31:0]            wid_r, wid_nxt, hgt_r, hgt_nxt, pd_r, pd_nxt;
  logic [31:0]            comp_r, comp_nxt, isz_r, isz_nxt, col_r, col_nxt;
  logic [3:0]             sig_r, sig_nxt;
  logic [31:0]            avail_r;
  logic [24:0]            maxdim_r;
  logic                   out_valid_r;
  out_item_t              out_data_r, out_nxt;

  logic                   accept, active, first, last, out_free;
  logic [7:0]             b;
  logic [SIZE_BITS-1:0]   p;
  logic [5:0]             ps;
  logic                   p_lo, core;
  logic [CW-1:0]          pw, hdr_end;
  logic                   emit;
  logic [1:0]             emit_status;
  logic                   mul_en;
  logic [31:0]            mul_a, mul_b;
  logic [63:0]            prod;
  logic [63:0]            row_sum;
  logic [31:0]            payload, habs;
  logic                   top, chk_fail;
  logic [3:0]             sig_len;

  bhv_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign first    = in_data.first_flag;
  assign last     = in_data.last_flag;
  assign b        = in_data.data_byte;
  assign active   = first || !verdict_r;
  assign p        = first ? '0 : pos_r;
  assign ps       = p[5:0];
  assign p_lo     = ~|p[SIZE_BITS-1:6];
  assign pw       = CW'(p);
  assign core     = (dib_r == DIB_CORE);
  assign hdr_end  = core ? CW'(25) : CW'(53);
  assign payload  = fsz_r - off_r;
  assign top      = !core && hgt_r[31];
  assign habs     = top ? (32'd0 - hgt_r) : hgt_r;
  assign row_sum  = prod + 64'd7;
  assign sig_len  = (comp_r == COMP_PNG) ? 4'd8 : 4'd3;

  always_comb begin
    chk_fail = 1'b0;
    if (!core && ((wid_r == 32'd0) || wid_r[31] || (hgt_r == 32'd0) ||
                  (hgt_r == 32'h8000_0000))) begin
      chk_fail = 1'b1;
    end
    if ((pd_r[15:0] != 16'd1) || (wid_r == 32'd0) || (habs == 32'd0) ||
        (wid_r > {7'd0, maxdim_r}) || (habs > {7'd0, maxdim_r}) ||
        !depth_ok(dib_r, pd_r[31:16], comp_r)) begin
      chk_fail = 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    verdict_nxt = verdict_r;
    last_nxt    = last_r;
    pos_nxt     = pos_r;
    fsz_nxt     = fsz_r;
    off_nxt     = off_r;
    dib_nxt     = dib_r;
    wid_nxt     = wid_r;
    hgt_nxt     = hgt_r;
    pd_nxt      = pd_r;
    comp_nxt    = comp_r;
    isz_nxt     = isz_r;
    col_nxt     = col_r;
    sig_nxt     = sig_r;
    emit        = 1'b0;
    emit_status = ST_VALID;
    mul_en      = 1'b0;
    mul_a       = wid_r;
    mul_b       = {16'd0, pd_r[31:16]};

    case (state_r)
      S_IDLE: begin
        if (accept && active) begin
          if (first) begin
            fsz_nxt  = '0;
            off_nxt  = '0;
            dib_nxt  = '0;
            wid_nxt  = '0;
            hgt_nxt  = '0;
            pd_nxt   = '0;
            comp_nxt = '0;
            isz_nxt  = '0;
            col_nxt  = '0;
            sig_nxt  = '0;
            verdict_nxt = 1'b0;
          end
          // field capture, little-endian lanes
          if (p_lo) begin
            case (ps) inside
              [6'd2:6'd5]:   fsz_nxt = put_lane(fsz_nxt, 2'(ps - 6'd2), b);
              [6'd10:6'd13]: off_nxt = put_lane(off_nxt, 2'(ps - 6'd10), b);
              [6'd14:6'd17]: dib_nxt = put_lane(dib_nxt, 2'(ps - 6'd14), b);
              default: begin
                if (ps >= 6'd18 && core) begin
                  if (ps <= 6'd19)      wid_nxt = put_lane(wid_nxt, 2'(ps - 6'd18), b);
                  else if (ps <= 6'd21) hgt_nxt = put_lane(hgt_nxt, 2'(ps - 6'd20), b);
                  else if (ps <= 6'd25) pd_nxt  = put_lane(pd_nxt, 2'(ps - 6'd22), b);
                end else if (ps >= 6'd18) begin
                  if (ps <= 6'd21)      wid_nxt  = put_lane(wid_nxt, 2'(ps - 6'd18), b);
                  else if (ps <= 6'd25) hgt_nxt  = put_lane(hgt_nxt, 2'(ps - 6'd22), b);
                  else if (ps <= 6'd29) pd_nxt   = put_lane(pd_nxt, 2'(ps - 6'd26), b);
                  else if (ps <= 6'd33) comp_nxt = put_lane(comp_nxt, 2'(ps - 6'd30), b);
                  else if (ps <= 6'd37) isz_nxt  = put_lane(isz_nxt, 2'(ps - 6'd34), b);
                  else if (ps >= 6'd46 && ps <= 6'd49) begin
                    col_nxt = put_lane(col_nxt, 2'(ps - 6'd46), b);
                  end
                end
              end
            endcase
          end

          if (pw == CW'(0)) begin
            if ((avail_r < 32'd18) || (b != 8'h42)) begin
              emit = 1'b1;
              emit_status = ST_REJECT;
            end
          end else if (pw == CW'(1)) begin
            if (b != 8'h4D) begin
              emit = 1'b1;
              emit_status = ST_REJECT;
            end
          end else if (pw == CW'(17)) begin
            if ((fsz_nxt == 32'd0) || (fsz_nxt > avail_r) || (off_nxt == 32'd0) ||
                (off_nxt > avail_r) || !dib_known(dib_nxt) ||
                ({1'b0, off_nxt} < ({1'b0, dib_nxt} + 33'd14)) || (off_nxt > fsz_nxt)) begin
              emit = 1'b1;
              emit_status = ST_REJECT;
            end
          end else if (pw >= CW'(18) && pw == hdr_end) begin
            // header complete: hand over to the check sequencer
            state_nxt = S_CHK;
          end else if (pw > hdr_end && pw >= CW'(18) &&
                       ((comp_r == COMP_JPEG) || (comp_r == COMP_PNG)) &&
                       pw >= CW'(off_r) && sig_r < sig_len) begin
            if (b != sig_byte(comp_r == COMP_PNG, sig_r)) begin
              emit = 1'b1;
              emit_status = ST_REJECT;
            end else begin
              sig_nxt = sig_r + 4'd1;
              if (sig_r + 4'd1 == sig_len) begin
                emit = 1'b1;
                emit_status = ST_VALID;
              end
            end
          end

          if (!emit && state_nxt == S_IDLE && last) begin
            emit = 1'b1;
            emit_status = ST_SHORT;
          end
          last_nxt = last;
          if (p != '1) begin
            pos_nxt = p + SIZE_BITS'(1);
          end else begin
            pos_nxt = p;
          end
          if (emit) begin
            verdict_nxt = 1'b1;
          end
        end
      end

      S_CHK: begin
        if (chk_fail) begin
          emit_status = ST_REJECT;
          emit = out_free;
        end else begin
          case (comp_r)
            32'd0, 32'd3, 32'd6: begin
              mul_en    = 1'b1;
              state_nxt = S_MUL1;
            end
            32'd1, 32'd2: begin
              emit_status = (payload < 32'd2) ? ST_REJECT : ST_VALID;
              emit = out_free;
            end
            32'd4, 32'd5: begin
              if (payload < ((comp_r == COMP_JPEG) ? 32'd3 : 32'd8)) begin
                emit_status = ST_REJECT;
                emit = out_free;
              end else if (last_r) begin
                emit_status = ST_SHORT;
                emit = out_free;
              end else begin
                // signature still to come
                state_nxt = S_IDLE;
              end
            end
            default: begin
              emit_status = ST_REJECT;
              emit = out_free;
            end
          endcase
        end
        if (emit) begin
          verdict_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      S_MUL1: begin
        // row bytes times absolute height
        mul_en    = 1'b1;
        mul_a     = row_sum[34:3];
        mul_b     = habs;
        state_nxt = S_MUL2;
      end

      S_MUL2: begin
        emit_status = (prod > {32'd0, payload}) ? ST_REJECT : ST_VALID;
        emit = out_free;
        if (emit) begin
          verdict_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_nxt = '0;
    out_nxt.status = emit_status;
    if (emit_status == ST_VALID) begin
      out_nxt.total_size        = fsz_r;
      out_nxt.pixel_offset      = off_r;
      out_nxt.dib_size          = dib_r[6:0];
      out_nxt.image_width       = wid_r[24:0];
      out_nxt.image_height      = habs[24:0];
      out_nxt.rows_top_down     = top;
      out_nxt.depth_bits        = pd_r[22:16];
      out_nxt.compression_kind  = comp_r[2:0];
      out_nxt.stated_image_size = isz_r;
      out_nxt.palette_count     = col_r;
      out_nxt.overlay_size      = avail_r - fsz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      verdict_r   <= 1'b1;
      last_r      <= 1'b0;
      pos_r       <= '0;
      fsz_r       <= '0;
      off_r       <= '0;
      dib_r       <= '0;
      wid_r       <= '0;
      hgt_r       <= '0;
      pd_r        <= '0;
      comp_r      <= '0;
      isz_r       <= '0;
      col_r       <= '0;
      sig_r       <= '0;
      avail_r     <= '0;
      maxdim_r    <= MAXDIM_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      verdict_r <= verdict_nxt;
      last_r    <= last_nxt;
      pos_r     <= pos_nxt;
      fsz_r     <= fsz_nxt;
      off_r     <= off_nxt;
      dib_r     <= dib_nxt;
      wid_r     <= wid_nxt;
      hgt_r     <= hgt_nxt;
      pd_r      <= pd_nxt;
      comp_r    <= comp_nxt;
      isz_r     <= isz_nxt;
      col_r     <= col_nxt;
      sig_r     <= sig_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_AVAIL:  avail_r  <= cfg_wdata;
          CFG_MAXDIM: maxdim_r <= cfg_wdata[24:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BHV_ASSERT(a_busy_stalls, (state_r != S_IDLE) |-> in_stall, "input taken while busy")
  `BHV_ASSERT(a_mul_order, (state_r == S_MUL2 && $past(state_r) != S_MUL2) |-> ($past(state_r) == S_MUL1), "second multiply without first")
  `BHV_ASSERT(a_reject_zero, (out_valid && out_data.status != ST_VALID) |-> (out_data.total_size == 32'd0 && out_data.overlay_size == 32'd0), "fields set on non-valid verdict")
  `BHV_ASSERT(a_verdict_idle, verdict_r |-> (state_r == S_IDLE), "sequencer active after verdict")
  `BHV_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid), "reset did not clear control")

endmodule

>>> rtl/core/bhv_mul.sv
// ----------------------------------------------------------------------------
// bhv_mul
// Shared 32x32 multiplier with a registered product, loaded on enable.
// ----------------------------------------------------------------------------
module bhv_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);
  import bhv_pkg::*;

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {32'd0, a} * {32'd0, b};
    end
  end

  assign prod = prod_r;

endmodule
